// ----- sv/sact_pkg.sv -----
// Shared types, codes and helper functions for the set-associative tag lookup.
// Used by the controller, the datapath and the top level; has no dependencies.
package sact_pkg;

    // Victim selection policy codes
    localparam logic [1:0] POL_FIFO   = 2'd0;
    localparam logic [1:0] POL_LRU    = 2'd1;
    localparam logic [1:0] POL_RANDOM = 2'd2;

    // Register index on the configuration port (address bit 2)
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_SEED   = 1'b1;

    // Random victim generator
    localparam int          LFSR_W    = 16;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [15:0] LFSR_ONE  = 16'h0001;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_we;  // write one zero row of the clearing pass
        logic capture;   // latch the accepted address
        logic lookup;    // compare, update the row and emit the result
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;  // clearing pass is at its last row
    } dp_status_t;

    // Floor of log2, evaluated at elaboration only
    function automatic int floor_log2(input int v);
        int n;
        int x;
        n = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            n++;
        end
        return n;
    endfunction

    // One right shift of the Galois LFSR
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] l);
        logic [LFSR_W-1:0] n;
        n = l >> 1;
        if (l[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

    // A zero seed would lock the LFSR, so it loads as one
    function automatic logic [LFSR_W-1:0] seed_fix(input logic [LFSR_W-1:0] s);
        return (s == '0) ? LFSR_ONE : s;
    endfunction

endpackage

// ----- sv/sact_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds one cache set per row in this design.
module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one row, read one row (old data on a same-address collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/sact_ctrl.sv -----
// Controller state machine: clearing pass after reset, idle, lookup.
// Depends on sact_pkg for the command and status structs.
module sact_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  sact_pkg::dp_status_t  status,
    output sact_pkg::dp_cmd_t     cmd,
    output logic                  busy
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.clear_we = 1'b0;
        cmd.capture  = 1'b0;
        cmd.lookup   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.capture = start;
                if (start)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the state; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- sv/sact_dp.sv -----
// Datapath: set RAM, way compare, victim choice, rank update, LFSR, totals.
// Depends on sact_pkg and instantiates sact_ram.
module sact_dp #(
    parameter int LINE_BYTES = 16,
    parameter int NUM_LINES  = 64,
    parameter int NUM_WAYS   = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sact_pkg::dp_cmd_t     cmd,
    output sact_pkg::dp_status_t  status,
    input  logic [31:0]           access_addr,
    input  logic [1:0]            policy,
    input  logic                  seed_we,
    input  logic [15:0]           seed_val,
    output logic                  done,
    output logic                  hit,
    output logic [1:0]            way_used,
    output logic                  evicted_valid,
    output logic [31:0]           access_total,
    output logic [31:0]           hit_total
);

    localparam int NUM_SETS  = NUM_LINES / NUM_WAYS;
    localparam int OFF_BITS  = sact_pkg::floor_log2(LINE_BYTES);
    localparam int IDX_BITS  = sact_pkg::floor_log2(NUM_SETS);
    localparam int SETS_USED = 1 << IDX_BITS;
    localparam int SET_W     = (IDX_BITS > 0) ? IDX_BITS : 1;
    localparam int SHIFT     = OFF_BITS + IDX_BITS;
    localparam int TAG_W     = 32 - SHIFT;
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int RANK_W    = WAY_W;
    localparam int CNT_W     = $clog2(NUM_WAYS + 1);
    localparam int ENTRY_W   = 1 + RANK_W + TAG_W;
    localparam int ROW_W     = NUM_WAYS * ENTRY_W;
    localparam int LW        = sact_pkg::LFSR_W;

    localparam logic [SET_W-1:0]  SET_MASK = SET_W'(SETS_USED - 1);
    localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(NUM_WAYS - 1);
    localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
    localparam logic [7:0]        MOD_K    = 8'(256 % NUM_WAYS);

    // Address split of the incoming item
    logic [SET_W-1:0] rd_set;
    logic [TAG_W-1:0] in_tag;

    assign rd_set = SET_W'(access_addr >> OFF_BITS) & SET_MASK;
    assign in_tag = TAG_W'(access_addr >> SHIFT);

    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [SET_W-1:0] clr_cnt_reg;

    // Latch the accepted address
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            set_reg <= rd_set;
            tag_reg <= in_tag;
        end
    end

    // Sweep the rows during the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_we)
        begin
            clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
        end
    end

    assign status.clear_last = (clr_cnt_reg == SET_MASK);

    // Set RAM: one row holds valid, rank and tag of every way
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] row_rd;
    logic [ROW_W-1:0] row_new;

    assign ram_we    = cmd.clear_we | cmd.lookup;
    assign ram_waddr = cmd.clear_we ? clr_cnt_reg : set_reg;
    assign ram_wdata = cmd.clear_we ? '0 : row_new;

    sact_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS_USED)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_set),
        .rdata (row_rd)
    );

    // Constant remainder table for the random way
    logic [WAY_W-1:0] mod_tab [256];

    for (genvar g = 0; g < 256; g++)
    begin : g_mod
        localparam int MODV = g % NUM_WAYS;
        assign mod_tab[g] = WAY_W'(MODV);
    end

    logic [LW-1:0]    lfsr_reg;
    logic [LW-1:0]    lfsr_nx;
    logic [WAY_W-1:0] rand_way_reg;
    logic [7:0]       fold;

    // Fold the next LFSR value into a way number, one register ahead of use
    assign lfsr_nx = sact_pkg::lfsr_step(lfsr_reg);
    assign fold    = 8'(mod_tab[lfsr_nx[15:8]]) * MOD_K + 8'(mod_tab[lfsr_nx[7:0]]);

    always_ff @(posedge clk)
    begin
        rand_way_reg <= mod_tab[fold];
    end

    // Unpack the row
    logic [NUM_WAYS-1:0] v;
    logic [RANK_W-1:0]   r  [NUM_WAYS];
    logic [TAG_W-1:0]    t  [NUM_WAYS];
    logic [ENTRY_W-1:0]  ent;

    always_comb
    begin
        ent = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            ent  = row_rd[i*ENTRY_W +: ENTRY_W];
            v[i] = ent[ENTRY_W-1];
            r[i] = ent[TAG_W +: RANK_W];
            t[i] = ent[TAG_W-1:0];
        end
    end

    // Compare all ways, find the first free way and the oldest way
    logic [CNT_W-1:0] nvalid;
    logic             hit_c;
    logic [WAY_W-1:0] hit_way;
    logic             free_found;
    logic [WAY_W-1:0] free_way;
    logic             age_found;
    logic [WAY_W-1:0] age_way;

    always_comb
    begin
        nvalid     = '0;
        hit_c      = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        age_found  = 1'b0;
        age_way    = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (v[i])
            begin
                nvalid = nvalid + CNT_ONE;
            end
            if (v[i] && (t[i] == tag_reg) && !hit_c)
            begin
                hit_c   = 1'b1;
                hit_way = WAY_W'(i);
            end
            if (!v[i] && !free_found)
            begin
                free_found = 1'b1;
                free_way   = WAY_W'(i);
            end
            if ((r[i] == '0) && !age_found)
            begin
                age_found = 1'b1;
                age_way   = WAY_W'(i);
            end
        end
    end

    // Pick the way for this item
    logic [WAY_W-1:0] victim;
    logic [WAY_W-1:0] way_sel;
    logic             evict_c;
    logic             do_promote;
    logic [RANK_W-1:0] old_rank;

    always_comb
    begin
        unique case (policy)
            sact_pkg::POL_FIFO:   victim = age_way;
            sact_pkg::POL_LRU:    victim = age_way;
            sact_pkg::POL_RANDOM: victim = rand_way_reg;
            default:              victim = '0;
        endcase
    end

    assign evict_c    = !hit_c && !free_found;
    assign way_sel    = hit_c ? hit_way : (free_found ? free_way : victim);
    assign do_promote = (hit_c && (policy == sact_pkg::POL_LRU)) || evict_c;
    assign old_rank   = r[way_sel];

    // New row: on fill, LRU hit or eviction the chosen way becomes newest
    logic [RANK_W-1:0] nr;
    logic              nv;
    logic [TAG_W-1:0]  nt;

    always_comb
    begin
        row_new = '0;
        nr      = '0;
        nv      = 1'b0;
        nt      = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            nr = r[i];
            nv = v[i];
            nt = t[i];
            if (WAY_W'(i) == way_sel)
            begin
                if (hit_c)
                begin
                    if (do_promote)
                    begin
                        nr = RANK_W'(nvalid - CNT_ONE);
                    end
                end
                else if (free_found)
                begin
                    nv = 1'b1;
                    nt = tag_reg;
                    nr = RANK_W'(nvalid);
                end
                else
                begin
                    nt = tag_reg;
                    nr = RANK_TOP;
                end
            end
            else if (do_promote && v[i] && (r[i] > old_rank))
            begin
                nr = r[i] - RANK_W'(1);
            end
            row_new[i*ENTRY_W +: ENTRY_W] = {nv, nr, nt};
        end
    end

    // Advance the LFSR on a random eviction; reload it on a seed write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= sact_pkg::LFSR_ONE;
        end
        else if (seed_we)
        begin
            lfsr_reg <= sact_pkg::seed_fix(seed_val);
        end
        else if (cmd.lookup && evict_c && (policy == sact_pkg::POL_RANDOM))
        begin
            lfsr_reg <= lfsr_nx;
        end
    end

    logic             done_reg;
    logic [31:0]      acc_cnt_reg;
    logic [31:0]      hit_cnt_reg;
    logic             hit_reg;
    logic [WAY_W-1:0] way_reg;
    logic             evict_reg;

    // Strobe and saturating totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            acc_cnt_reg <= '0;
            hit_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= cmd.lookup;
            if (cmd.lookup)
            begin
                if (acc_cnt_reg != '1)
                begin
                    acc_cnt_reg <= acc_cnt_reg + 32'd1;
                end
                if (hit_c && (hit_cnt_reg != '1))
                begin
                    hit_cnt_reg <= hit_cnt_reg + 32'd1;
                end
            end
        end
    end

    // Hold the result fields
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_reg   <= hit_c;
            way_reg   <= way_sel;
            evict_reg <= evict_c;
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign way_used      = 2'(way_reg);
    assign evicted_valid = evict_reg;
    assign access_total  = acc_cnt_reg;
    assign hit_total     = hit_cnt_reg;

endmodule

// ----- sv/set_assoc_cache_tag_lookup.sv -----
// Top level of the set-associative tag lookup: configuration registers and
// the controller/datapath pair. Depends on sact_pkg, sact_ctrl, sact_dp.
//
// Usage:
//   Drive access_addr and raise start; the item is taken at a clock edge where
//   start is high and busy is low. The result (hit, way_used, evicted_valid,
//   access_total, hit_total) appears with done high for exactly one cycle,
//   registered at the end of the lookup state. The receiver cannot stall it.
//   An item passes two steps: the set's row is read from the set RAM at the
//   accepting edge, then in the lookup state all ways are compared, the way
//   picked and the row written back. busy is low again in the cycle that
//   shows done, so a new item can be taken then.
//   After reset busy stays high while a clearing pass zeroes every row of the
//   set RAM, one row per set (16 with the default parameters).
//   Registers sit on the APB port: replace_policy at 0x0, random_seed at 0x4;
//   writing random_seed also reloads the victim LFSR. Write them only while
//   the block is idle.
module set_assoc_cache_tag_lookup #(
    parameter int LINE_BYTES = 16,
    parameter int NUM_LINES  = 64,
    parameter int NUM_WAYS   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] access_addr,
    output logic        done,
    output logic        hit,
    output logic [1:0]  way_used,
    output logic        evicted_valid,
    output logic [31:0] access_total,
    output logic [31:0] hit_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sact_pkg::dp_cmd_t    cmd;
    sact_pkg::dp_status_t status;

    logic [1:0]  policy_reg;
    logic [15:0] seed_reg;
    logic        cfg_wr;
    logic        seed_we;

    // Decode register writes
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign seed_we = cfg_wr && (paddr[2] == sact_pkg::REG_SEED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= sact_pkg::POL_LRU;
            seed_reg   <= 16'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                sact_pkg::REG_POLICY: policy_reg <= pwdata[1:0];
                sact_pkg::REG_SEED:   seed_reg   <= pwdata[15:0];
                default:              policy_reg <= policy_reg;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        unique case (paddr[2])
            sact_pkg::REG_POLICY: prdata = {30'd0, policy_reg};
            sact_pkg::REG_SEED:   prdata = {16'd0, seed_reg};
            default:              prdata = '0;
        endcase
    end

    sact_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sact_dp #(
        .LINE_BYTES (LINE_BYTES),
        .NUM_LINES  (NUM_LINES),
        .NUM_WAYS   (NUM_WAYS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .access_addr   (access_addr),
        .policy        (policy_reg),
        .seed_we       (seed_we),
        .seed_val      (pwdata[15:0]),
        .done          (done),
        .hit           (hit),
        .way_used      (way_used),
        .evicted_valid (evicted_valid),
        .access_total  (access_total),
        .hit_total     (hit_total)
    );

endmodule

// ----- sv/sact_checker.sv -----
// Port-level checker for the tag lookup, bound to the top level.
// No dependencies beyond the top level's ports.
module sact_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        hit,
    input logic        evicted_valid,
    input logic [31:0] access_total,
    input logic [31:0] hit_total
);

    // An accepted item makes the block busy for its lookup cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // Every accepted item gives its result strobe after its lookup state
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result strobe missing after accepted item");

    // Results never come on consecutive cycles
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe on back-to-back cycles");

    // A hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> !evicted_valid)
        else $error("hit reported with eviction");

    // Hits never outnumber accesses
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hit_total <= access_total))
        else $error("hit total exceeds access total");

endmodule

bind set_assoc_cache_tag_lookup sact_checker u_sact_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .access_total  (access_total),
    .hit_total     (hit_total)
);
